// ----- design/log_camera_curve_transform_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef LOG_CAMERA_CURVE_TRANSFORM_MACROS_SVH
`define LOG_CAMERA_CURVE_TRANSFORM_MACROS_SVH

// Checked on every clock edge outside of reset.
`define LCCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lcct assertion failed");

// Checked on every clock edge, reset included.
`define LCCT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lcct assertion failed");

`endif

// ----- design/lcct_pkg.sv -----
package lcct_pkg;

  localparam int FRAC_BITS_DEF  = 20;
  localparam int TABLE_BITS_DEF = 8;
  localparam int MAX_TABLE_BITS = 12;
  localparam int CFG_INDEX_W    = 8;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [63:0] HALF30  = 64'd1 << 29;

  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BREAK     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIN_GAIN  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LIN_BIAS  = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PRE_GAIN  = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PRE_BIAS  = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_POST_GAIN = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_POST_BIAS = 8'd7;

  typedef struct packed {
    logic               direction;
    logic signed [31:0] seg_break;
    logic signed [31:0] lin_gain;
    logic signed [31:0] lin_bias;
    logic signed [31:0] pre_gain;
    logic signed [31:0] pre_bias;
    logic signed [31:0] post_gain;
    logic signed [31:0] post_bias;
  } cfg_t;

  typedef logic [31:0] root_tab_t [MAX_TABLE_BITS+1];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Entry k holds 2^(2^-k) in Q2.30.
  function automatic root_tab_t root_table();
    root_tab_t   tab;
    logic [63:0] c;
    c      = 64'd1 << 31;
    tab[0] = c[31:0];
    for (int k = 1; k <= MAX_TABLE_BITS; k++) begin
      c      = isqrt64(c << 30);
      tab[k] = c[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = root_table();

endpackage

// ----- design/lcct_affine.sv -----
module lcct_affine import lcct_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] gain,
  input  logic signed [31:0] bias,
  input  logic signed [31:0] x,
  output logic signed [31:0] y
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prod;
  logic signed [31:0] bias_q;
  logic signed [63:0] rounded;
  logic signed [64:0] sum;
  logic signed [31:0] y_next;

  always_ff @(posedge clk) begin
    prod   <= gain * x;
    bias_q <= bias;
    y      <= y_next;
  end

  always_comb begin
    rounded = (prod + HALF) >>> FRAC_BITS;
    sum     = 65'(rounded) + 65'(bias_q);
    if (sum > 65'sd2147483647) begin
      y_next = 32'sh7fff_ffff;
    end else if (sum < -65'sd2147483648) begin
      y_next = 32'sh8000_0000;
    end else begin
      y_next = sum[31:0];
    end
  end

endmodule

// ----- design/lcct_exp2.sv -----
module lcct_exp2 import lcct_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] x,
  output logic signed [31:0] y
);

  localparam int T  = (TABLE_BITS < FRAC_BITS) ? TABLE_BITS : FRAC_BITS;
  localparam int NW = 32 - FRAC_BITS;
  localparam int LW = FRAC_BITS + 30;
  localparam logic [FRAC_BITS-1:0] RMASK =
    FRAC_BITS'((64'd1 << (FRAC_BITS - T)) - 64'd1);

  logic [31:0]           m_in [T];
  logic [FRAC_BITS-1:0]  f_in [T];
  logic signed [NW-1:0]  n_in [T];
  logic [29:0]           l_in [T];
  logic [31:0]           m_st [T];
  logic [FRAC_BITS-1:0]  f_st [T];
  logic signed [NW-1:0]  n_st [T];
  logic [29:0]           l_st [T];
  logic [LW-1:0]         lprod;
  logic [63:0]           prod2;
  logic [31:0]           m_c;
  logic signed [NW-1:0]  n_c;
  logic [32:0]           m2;
  logic signed [NW-1:0]  n2;
  logic signed [NW+1:0]  s;
  logic [5:0]            sh;
  logic [63:0]           wide;
  logic signed [31:0]    y_next;

  always_comb begin
    lprod   = LW'(x[FRAC_BITS-1:0] & RMASK) * LW'(LN2_Q30);
    m_in[0] = 32'h4000_0000;
    f_in[0] = x[FRAC_BITS-1:0];
    n_in[0] = x[31:FRAC_BITS];
    l_in[0] = lprod[FRAC_BITS +: 30];
    for (int k = 1; k < T; k++) begin
      m_in[k] = m_st[k-1];
      f_in[k] = f_st[k-1];
      n_in[k] = n_st[k-1];
      l_in[k] = l_st[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < T; k++) begin
      m_st[k] <= f_in[k][FRAC_BITS-1-k] ?
                 32'((64'(m_in[k]) * 64'(ROOT_TAB[k+1]) + HALF30) >> 30) : m_in[k];
      f_st[k] <= f_in[k];
      n_st[k] <= n_in[k];
      l_st[k] <= l_in[k];
    end
    prod2 <= 64'(m_st[T-1]) * 64'(l_st[T-1]);
    m_c   <= m_st[T-1];
    n_c   <= n_st[T-1];
    m2    <= 33'(m_c) + 33'((prod2 + HALF30) >> 30);
    n2    <= n_c;
    y     <= y_next;
  end

  always_comb begin
    s      = (NW+2)'(n2) + (NW+2)'(FRAC_BITS - 30);
    sh     = 6'(-s);
    wide   = 64'd0;
    y_next = 32'sd0;
    if (s > 0) begin
      y_next = 32'sh7fff_ffff;
    end else if (s == 0) begin
      y_next = (m2 > 33'h0_7fff_ffff) ? 32'sh7fff_ffff : m2[31:0];
    end else if (s < -62) begin
      y_next = 32'sd0;
    end else begin
      wide   = (64'(m2) + (64'd1 << (sh - 6'd1))) >> sh;
      y_next = (wide > 64'h7fff_ffff) ? 32'sh7fff_ffff : wide[31:0];
    end
  end

endmodule

// ----- design/lcct_log2.sv -----
module lcct_log2 import lcct_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] x,
  output logic signed [31:0] y
);

  localparam int T = (TABLE_BITS < FRAC_BITS) ? TABLE_BITS : FRAC_BITS;
  localparam logic signed [63:0] FRAC_S = 64'(FRAC_BITS);

  logic [30:0]        xc;
  logic [4:0]         p_lead;
  logic [30:0]        v_a;
  logic [4:0]         p_a;
  logic [30:0]        m_b;
  logic [4:0]         p_b;
  logic [30:0]        m_in    [T];
  logic [T-1:0]       bits_in [T];
  logic [4:0]         p_in    [T];
  logic [31:0]        sq      [T];
  logic [30:0]        m_st    [T];
  logic [T-1:0]       bits_st [T];
  logic [4:0]         p_st    [T];
  logic signed [63:0] term1;
  logic signed [63:0] term2;
  logic signed [63:0] term3;
  logic signed [63:0] res;
  logic signed [31:0] y_next;

  always_comb begin
    xc     = (x < 32'sd1) ? 31'd1 : x[30:0];
    p_lead = 5'd0;
    for (int i = 1; i < 31; i++) begin
      if (xc[i]) begin
        p_lead = 5'(i);
      end
    end
  end

  always_comb begin
    m_in[0]    = m_b;
    bits_in[0] = '0;
    p_in[0]    = p_b;
    for (int k = 1; k < T; k++) begin
      m_in[k]    = m_st[k-1];
      bits_in[k] = bits_st[k-1];
      p_in[k]    = p_st[k-1];
    end
    for (int k = 0; k < T; k++) begin
      sq[k] = 32'((64'(m_in[k]) * 64'(m_in[k]) + HALF30) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    v_a <= xc;
    p_a <= p_lead;
    m_b <= v_a << (5'd30 - p_a);
    p_b <= p_a;
    for (int k = 0; k < T; k++) begin
      m_st[k]    <= sq[k][31] ? sq[k][31:1] : sq[k][30:0];
      bits_st[k] <= (bits_in[k] << 1) | T'(sq[k][31]);
      p_st[k]    <= p_in[k];
    end
    y <= y_next;
  end

  always_comb begin
    term1 = (signed'({59'd0, p_st[T-1]}) - FRAC_S) <<< FRAC_BITS;
    term2 = signed'(64'(bits_st[T-1]) << (FRAC_BITS - T));
    term3 = signed'(64'((m_st[T-1] - 31'h4000_0000) >> (30 - FRAC_BITS + T)));
    res   = term1 + term2 + term3;
    if (res > 64'sd2147483647) begin
      y_next = 32'sh7fff_ffff;
    end else if (res < -64'sd2147483648) begin
      y_next = 32'sh8000_0000;
    end else begin
      y_next = res[31:0];
    end
  end

endmodule

// ----- design/lcct_channel.sv -----
module lcct_channel import lcct_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic               clk,
  input  cfg_t               cfg,
  input  logic signed [31:0] x,
  output logic signed [31:0] y
);

  localparam int T        = (TABLE_BITS < FRAC_BITS) ? TABLE_BITS : FRAC_BITS;
  localparam int CURVE_LAT = T + 3;
  localparam int T_DLY     = CURVE_LAT + 2;
  localparam int LIN_DLY   = CURVE_LAT + 4;

  logic               lin;
  logic signed [31:0] gain_sel;
  logic signed [31:0] bias_sel;
  logic signed [31:0] t;
  logic signed [31:0] exp_y;
  logic signed [31:0] log_y;
  logic signed [31:0] curve_y;
  logic signed [31:0] post_y;
  logic signed [31:0] t_line   [T_DLY];
  logic               lin_line [LIN_DLY];

  always_comb begin
    lin      = x < cfg.seg_break;
    gain_sel = lin ? cfg.lin_gain : cfg.pre_gain;
    bias_sel = lin ? cfg.lin_bias : cfg.pre_bias;
    curve_y  = cfg.direction ? log_y : exp_y;
    y        = lin_line[LIN_DLY-1] ? t_line[T_DLY-1] : post_y;
  end

  always_ff @(posedge clk) begin
    t_line[0]   <= t;
    lin_line[0] <= lin;
    for (int i = 1; i < T_DLY; i++) begin
      t_line[i] <= t_line[i-1];
    end
    for (int i = 1; i < LIN_DLY; i++) begin
      lin_line[i] <= lin_line[i-1];
    end
  end

  lcct_affine #(.FRAC_BITS(FRAC_BITS)) u_pre (
    .clk  (clk),
    .gain (gain_sel),
    .bias (bias_sel),
    .x    (x),
    .y    (t)
  );

  lcct_exp2 #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_exp2 (
    .clk (clk),
    .x   (t),
    .y   (exp_y)
  );

  lcct_log2 #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_log2 (
    .clk (clk),
    .x   (t),
    .y   (log_y)
  );

  lcct_affine #(.FRAC_BITS(FRAC_BITS)) u_post (
    .clk  (clk),
    .gain (cfg.post_gain),
    .bias (cfg.post_bias),
    .x    (curve_y),
    .y    (post_y)
  );

endmodule

// ----- design/log_camera_curve_transform.sv -----
// Throughput: one item per cycle; busy stays low and done can never be held off.
// The depth is set by one multiplier stage per table bit in the exp2 and log2 units.
// Synchronous reset restores the register defaults and drops every item in flight.
`include "log_camera_curve_transform_macros.svh"

module log_camera_curve_transform import lcct_pkg::*; #(
  parameter int FRAC_BITS         = FRAC_BITS_DEF,
  parameter int APPROX_TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     red_in,
  input  logic signed [31:0]     green_in,
  input  logic signed [31:0]     blue_in,
  output logic                   done,
  output logic signed [31:0]     red_out,
  output logic signed [31:0]     green_out,
  output logic signed [31:0]     blue_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int T   = (APPROX_TABLE_BITS < FRAC_BITS) ? APPROX_TABLE_BITS : FRAC_BITS;
  localparam int LAT = T + 7;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  cfg_t           cfg;
  logic [LAT-1:0] vld;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign done      = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction <= 1'b0;
      cfg.seg_break <= 32'sd0;
      cfg.lin_gain  <= ONE_FX;
      cfg.lin_bias  <= 32'sd0;
      cfg.pre_gain  <= ONE_FX;
      cfg.pre_bias  <= 32'sd0;
      cfg.post_gain <= ONE_FX;
      cfg.post_bias <= 32'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIRECTION: cfg.direction <= cfg_data[0];
        REG_BREAK:     cfg.seg_break <= cfg_data;
        REG_LIN_GAIN:  cfg.lin_gain  <= cfg_data;
        REG_LIN_BIAS:  cfg.lin_bias  <= cfg_data;
        REG_PRE_GAIN:  cfg.pre_gain  <= cfg_data;
        REG_PRE_BIAS:  cfg.pre_bias  <= cfg_data;
        REG_POST_GAIN: cfg.post_gain <= cfg_data;
        REG_POST_BIAS: cfg.post_bias <= cfg_data;
        default: ;
      endcase
    end
  end

  lcct_channel #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(APPROX_TABLE_BITS)) u_red (
    .clk (clk),
    .cfg (cfg),
    .x   (red_in),
    .y   (red_out)
  );

  lcct_channel #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(APPROX_TABLE_BITS)) u_green (
    .clk (clk),
    .cfg (cfg),
    .x   (green_in),
    .y   (green_out)
  );

  lcct_channel #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(APPROX_TABLE_BITS)) u_blue (
    .clk (clk),
    .cfg (cfg),
    .x   (blue_in),
    .y   (blue_out)
  );

  `LCCT_ASSERT(a_done_from_start, done |-> $past(start, LAT))
  `LCCT_ASSERT(a_start_to_done, start |-> ##LAT done)
  `LCCT_ASSERT(a_dir_write, (cfg_valid && cfg_ready && cfg_index == REG_DIRECTION) |=> (cfg.direction == $past(cfg_data[0])))
  `LCCT_ASSERT_ALWAYS(a_rst_flush, rst |=> !done)

endmodule
